// ===== hw/rtl/pcc_pkg.sv =====
// Shared types, format codes and encode tables for the pixel clear compare block.
package pcc_pkg;

  // Format codes
  localparam logic [7:0] FmtRgba0    = 8'd27;
  localparam logic [7:0] FmtRgba1    = 8'd28;
  localparam logic [7:0] FmtRgbaSrgb = 8'd29;
  localparam logic [7:0] FmtBgra0    = 8'd87;
  localparam logic [7:0] FmtBgra1    = 8'd90;
  localparam logic [7:0] FmtBgraSrgb = 8'd91;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // sRGB linear segment: v <= 205 (0.0031308 of full scale)
  localparam logic [15:0] SrgbLinLimit = 16'd205;
  localparam longint SrgbLinSlope2 = 65892;    // 2 * 32946, i.e. 2 * 10 * 12.92 * 255
  localparam longint SrgbLinBias   = 655350;
  localparam longint SrgbLinDiv    = 1310700;
  // Power segment, exact integer form of 1.055 * x^(1/2.4) - 0.055
  localparam int SrgbGamNum  = 10761;
  localparam int SrgbStepMul = 40;
  localparam int SrgbStepOff = 541;
  localparam int FullScale   = 65535;

  // Unorm: floor((v + 128) / 257) by reciprocal multiply
  localparam logic [16:0] UnormBias  = 17'd128;
  localparam logic [16:0] UnormRecip = 17'd130562;
  localparam int          UnormShift = 25;

  localparam logic [7:0] ByteMax = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXP_RED   = 3'd0,
    REG_EXP_GREEN = 3'd1,
    REG_EXP_BLUE  = 3'd2,
    REG_EXP_ALPHA = 3'd3,
    REG_TOL       = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STAT_RB_FAIL   = 2'd0,
    STAT_UNDECODED = 2'd1,
    STAT_PASS      = 2'd2,
    STAT_FAIL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ORD_NONE = 2'd0,
    ORD_RGBA = 2'd1,
    ORD_BGRA = 2'd2
  } order_e;

  typedef struct packed {
    logic       readback_ok;
    logic [7:0] raw_byte0;
    logic [7:0] raw_byte1;
    logic [7:0] raw_byte2;
    logic [7:0] raw_byte3;
    logic [7:0] texture_code;
    logic [7:0] view_code;
  } pix_in_t;

  typedef struct packed {
    status_e     status;
    logic        all_zero;
    logic [31:0] observed_rgba;
    logic [31:0] expected_rgba;
    logic [7:0]  largest_delta;
    logic [1:0]  worst_index;
    logic        used_srgb;
  } pix_out_t;

  // Pre-encoded expected color, refreshed on each register write
  typedef struct packed {
    logic [2:0][7:0] exp_srgb;
    logic [2:0][7:0] exp_unorm;
    logic [7:0]      exp_alpha;
    logic [7:0]      tolerance;
  } pcc_cfg_t;

  typedef logic [255:0][15:0] thr_tab_t;
  typedef logic [15:0][15:0]  low_tab_t;

  // Entry k: smallest linear value whose sRGB byte is at least k (power segment form).
  function automatic thr_tab_t build_srgb_thr();
    thr_tab_t     tab;
    logic [255:0] c12;
    logic [255:0] m5;
    logic [255:0] base;
    logic [255:0] rhs;
    logic [255:0] vv;
    logic [255:0] lhs;
    int           lo;
    int           hi;
    int           mid;
    tab = '0;
    c12 = 256'd1;
    m5  = 256'd1;
    for (int i = 0; i < 12; i++) c12 = c12 * 256'(SrgbGamNum);
    for (int i = 0; i < 5; i++) m5 = m5 * 256'(FullScale);
    for (int k = 1; k < 256; k++) begin
      base = 256'(SrgbStepMul * k + SrgbStepOff);
      rhs  = m5;
      for (int i = 0; i < 12; i++) rhs = rhs * base;
      lo = 0;
      hi = FullScale;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        vv  = 256'(mid);
        lhs = vv * vv * vv * vv * vv * c12;
        if (lhs >= rhs) hi = mid;
        else lo = mid + 1;
      end
      tab[k] = 16'(lo);
    end
    return tab;
  endfunction

  // Entry j: smallest linear value whose linear-segment byte is at least j.
  function automatic low_tab_t build_low_thr();
    low_tab_t tab;
    longint   num;
    tab = '0;
    for (int j = 1; j < 16; j++) begin
      num    = longint'(j) * SrgbLinDiv - SrgbLinBias;
      tab[j] = 16'((num + SrgbLinSlope2 - 1) / SrgbLinSlope2);
    end
    return tab;
  endfunction

  localparam thr_tab_t SrgbThr = build_srgb_thr();
  localparam low_tab_t SrgbLowThr = build_low_thr();

endpackage

// ===== hw/rtl/pcc_encoder.sv =====
// Encodes one linear 0.16 value to sRGB and unorm bytes.
module pcc_encoder import pcc_pkg::*; (
  input  logic [15:0] lin_i,
  output logic [7:0]  srgb_o,
  output logic [7:0]  unorm_o
);

  logic [7:0]  hi_code;
  logic [3:0]  lo_code;
  logic [16:0] unorm_x;
  logic [33:0] unorm_prod;

  // Largest k with threshold[k] <= v; tables are monotone, threshold[0] is 0
  always_comb begin
    hi_code = '0;
    for (int b = 7; b >= 0; b--) begin
      if (SrgbThr[hi_code | (8'd1 << b)] <= lin_i) hi_code = hi_code | (8'd1 << b);
    end
  end

  always_comb begin
    lo_code = '0;
    for (int b = 3; b >= 0; b--) begin
      if (SrgbLowThr[lo_code | (4'd1 << b)] <= lin_i) lo_code = lo_code | (4'd1 << b);
    end
  end

  assign srgb_o = (lin_i <= SrgbLinLimit) ? {4'd0, lo_code} : hi_code;

  assign unorm_x    = {1'b0, lin_i} + UnormBias;
  assign unorm_prod = {17'd0, unorm_x} * {17'd0, UnormRecip};
  assign unorm_o    = unorm_prod[UnormShift +: 8];

endmodule

// ===== hw/rtl/pcc_cfg.sv =====
// Configuration registers, holding the expected color already encoded.
module pcc_cfg import pcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output pcc_cfg_t            cfg_o
);

  pcc_cfg_t   cfg_d, cfg_q;
  logic [7:0] enc_srgb;
  logic [7:0] enc_unorm;

  pcc_encoder u_encoder (
    .lin_i   (cfg_wdata_i),
    .srgb_o  (enc_srgb),
    .unorm_o (enc_unorm)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_EXP_RED: begin
          cfg_d.exp_srgb[0]  = enc_srgb;
          cfg_d.exp_unorm[0] = enc_unorm;
        end
        REG_EXP_GREEN: begin
          cfg_d.exp_srgb[1]  = enc_srgb;
          cfg_d.exp_unorm[1] = enc_unorm;
        end
        REG_EXP_BLUE: begin
          cfg_d.exp_srgb[2]  = enc_srgb;
          cfg_d.exp_unorm[2] = enc_unorm;
        end
        REG_EXP_ALPHA: cfg_d.exp_alpha = enc_unorm;
        REG_TOL:       cfg_d.tolerance = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Reset color is opaque black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{exp_srgb: '0, exp_unorm: '0, exp_alpha: ByteMax, tolerance: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/pcc_judge.sv =====
// Decodes one pixel word and compares it with the expected color.
module pcc_judge import pcc_pkg::*; (
  input  pix_in_t  item_i,
  input  pcc_cfg_t cfg_i,
  output pix_out_t res_o
);

  order_e          tex_order;
  order_e          view_order;
  logic            tex_srgb;
  logic            view_srgb;
  logic            use_srgb;
  logic [3:0][7:0] obs;
  logic [3:0][7:0] expv;
  logic [7:0]      delta;
  logic [7:0]      max_d;
  logic [1:0]      worst;

  function automatic order_e classify(logic [7:0] code);
    order_e ord;
    unique case (code)
      FmtRgba0, FmtRgba1, FmtRgbaSrgb: ord = ORD_RGBA;
      FmtBgra0, FmtBgra1, FmtBgraSrgb: ord = ORD_BGRA;
      default:                         ord = ORD_NONE;
    endcase
    return ord;
  endfunction

  assign tex_order  = classify(item_i.texture_code);
  assign view_order = classify(item_i.view_code);
  assign tex_srgb   = (item_i.texture_code == FmtRgbaSrgb) ||
                      (item_i.texture_code == FmtBgraSrgb);
  assign view_srgb  = (item_i.view_code == FmtRgbaSrgb) ||
                      (item_i.view_code == FmtBgraSrgb);
  assign use_srgb   = (view_order != ORD_NONE) ? view_srgb : tex_srgb;

  assign obs[0] = (tex_order == ORD_BGRA) ? item_i.raw_byte2 : item_i.raw_byte0;
  assign obs[1] = item_i.raw_byte1;
  assign obs[2] = (tex_order == ORD_BGRA) ? item_i.raw_byte0 : item_i.raw_byte2;
  assign obs[3] = item_i.raw_byte3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      expv[i] = use_srgb ? cfg_i.exp_srgb[i] : cfg_i.exp_unorm[i];
    end
    expv[3] = cfg_i.exp_alpha;
  end

  // Strict compare keeps the first channel that reaches the maximum
  always_comb begin
    max_d = '0;
    worst = '0;
    delta = '0;
    for (int i = 0; i < 4; i++) begin
      delta = (obs[i] > expv[i]) ? obs[i] - expv[i] : expv[i] - obs[i];
      if (delta > max_d) begin
        max_d = delta;
        worst = 2'(i);
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (item_i.readback_ok) begin
      res_o.all_zero = ~|{item_i.raw_byte0, item_i.raw_byte1,
                          item_i.raw_byte2, item_i.raw_byte3};
      if (tex_order == ORD_NONE) begin
        res_o.status = STAT_UNDECODED;
      end else begin
        res_o.status        = (max_d <= cfg_i.tolerance) ? STAT_PASS : STAT_FAIL;
        res_o.observed_rgba = obs;
        res_o.expected_rgba = expv;
        res_o.largest_delta = max_d;
        res_o.worst_index   = worst;
        res_o.used_srgb     = use_srgb;
      end
    end
  end

endmodule

// ===== hw/rtl/pixel_clear_compare.sv =====
// Pixel clear compare: checks read-back pixels against an expected color.
// Registers in order: input register, then result register; the compare is one pass of
// logic between them. One word per cycle while out_ready_i does not stall the output.
// Register writes take effect at the next edge; encoding is done at write time.
// Reset clears both pipeline valids and loads the register reset values.
module pixel_clear_compare import pcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pix_out_t            out_data_o
);

  pcc_cfg_t cfg;
  logic     s1_valid_q, s1_valid_d;
  pix_in_t  s1_data_q;
  logic     out_valid_q, out_valid_d;
  pix_out_t out_data_q;
  pix_out_t judge_res;
  logic     s1_adv;
  logic     in_take;

  pcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pcc_judge u_judge (
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (judge_res)
  );

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) s1_data_q <= in_data_i;
    if (s1_adv && s1_valid_q) out_data_q <= judge_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
